[rtl/core/pwct_pkg.sv]
// Shared types, constants and helpers for the pulse width code transmitter.
package pwct_pkg;

   localparam int LEN_W   = 16;  // width of every pulse or gap length register
   localparam int REP_W   = 4;   // width of the repeat count and the pass counter
   localparam int PHASE_W = 2;
   localparam int CSR_IDX_W = 2;

   // Sequencer phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HIGH = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_GAP  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LEN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LEN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_TOTAL = 2'd3;

   // Register reset values
   localparam logic [LEN_W-1:0] SHORT_LEN_RST    = 16'd150;
   localparam logic [LEN_W-1:0] LONG_LEN_RST     = 16'd450;
   localparam logic [LEN_W-1:0] GAP_LEN_RST      = 16'd4800;
   localparam logic [REP_W-1:0] REPEAT_TOTAL_RST = 4'd8;

   typedef struct packed {
      logic [LEN_W-1:0] short_len;
      logic [LEN_W-1:0] long_len;
      logic [LEN_W-1:0] gap_len;
      logic [REP_W-1:0] repeat_total;
   } cfg_type;

   typedef struct packed {
      logic pin;
      logic busy;
      logic done;
   } result_type;

   // A length of zero counts as one tick.
   function automatic logic [LEN_W-1:0] len_at_least_one(input logic [LEN_W-1:0] len);
      len_at_least_one = (len == '0) ? LEN_W'(1) : len;
   endfunction

endpackage

[rtl/core/pwct_seq.sv]
// Frame sequencer: code store, bit, pass and tick counters of the transmitter.
module pwct_seq #(
   parameter int CODE_BITS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 func,
   input  logic [CODE_BITS-1:0] code,
   input  pwct_pkg::cfg_type    cfg,
   output pwct_pkg::result_type result
);
   import pwct_pkg::*;

   localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(CODE_BITS - 1);

   logic [CODE_BITS-1:0] code_store_ff, code_store_in;
   logic [BIT_W-1:0]     bit_pos_ff, bit_pos_in;
   logic [REP_W-1:0]     pass_ff, pass_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [LEN_W-1:0]     time_left_ff, time_left_in;

   logic [LEN_W-1:0] short1, long1, gap1, time_dec;
   logic [REP_W-1:0] rep1;
   logic [REP_W:0]   pass_sum;
   logic             cur_bit, ld_bit;

   assign short1   = len_at_least_one(cfg.short_len);
   assign long1    = len_at_least_one(cfg.long_len);
   assign gap1     = len_at_least_one(cfg.gap_len);
   assign rep1     = (cfg.repeat_total == '0) ? REP_W'(1) : cfg.repeat_total;
   assign time_dec = time_left_ff - LEN_W'(1);
   assign pass_sum = {1'b0, pass_ff} + (REP_W+1)'(1);
   assign cur_bit  = code_store_ff[BIT_LAST - bit_pos_ff];

   always_comb begin
      code_store_in = code_store_ff;
      bit_pos_in    = bit_pos_ff;
      pass_in       = pass_ff;
      phase_in      = phase_ff;
      time_left_in  = time_left_ff;
      result        = '0;
      ld_bit        = 1'b0;

      if (func) begin
         result.busy = 1'b1;
         if (phase_ff == PH_IDLE) begin
            // load the word and open the first high part
            code_store_in = code;
            bit_pos_in    = '0;
            pass_in       = '0;
            phase_in      = PH_HIGH;
            time_left_in  = code[CODE_BITS-1] ? long1 : short1;
            result.pin    = 1'b1;
         end else begin
            result.pin = (phase_ff == PH_HIGH);
         end
      end else if (phase_ff != PH_IDLE) begin
         result.pin   = (phase_ff == PH_HIGH);
         result.busy  = 1'b1;
         time_left_in = time_dec;
         if (time_dec == '0) begin
            case (phase_ff)
               PH_HIGH: begin
                  phase_in     = PH_LOW;
                  time_left_in = cur_bit ? short1 : long1;
               end
               PH_LOW: begin
                  if (bit_pos_ff >= BIT_LAST) begin
                     phase_in     = PH_GAP;
                     time_left_in = gap1;
                  end else begin
                     bit_pos_in   = bit_pos_ff + BIT_W'(1);
                     ld_bit       = code_store_ff[BIT_LAST - bit_pos_in];
                     phase_in     = PH_HIGH;
                     time_left_in = ld_bit ? long1 : short1;
                  end
               end
               default: begin
                  pass_in    = pass_sum[REP_W-1:0];
                  bit_pos_in = '0;
                  if (pass_sum >= {1'b0, rep1}) begin
                     phase_in    = PH_IDLE;
                     result.done = 1'b1;
                  end else begin
                     ld_bit       = code_store_ff[BIT_LAST];
                     phase_in     = PH_HIGH;
                     time_left_in = ld_bit ? long1 : short1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_store_ff <= '0;
         bit_pos_ff    <= '0;
         pass_ff       <= '0;
         phase_ff      <= PH_IDLE;
         time_left_ff  <= '0;
      end else if (step) begin
         code_store_ff <= code_store_in;
         bit_pos_ff    <= bit_pos_in;
         pass_ff       <= pass_in;
         phase_ff      <= phase_in;
         time_left_ff  <= time_left_in;
      end
   end

endmodule

[rtl/core/pulse_width_code_transmitter.sv]
// Top level of the pulse width on/off-keyed code transmitter.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   req      | req_valid / req_ready | req_func, req_code
//   rsp      | rsp_valid / rsp_ready | rsp_pin, rsp_busy_res, rsp_done_res
//   csr      | csr_we (write only)   | csr_index, csr_wdata
//
// Every req beat yields exactly one rsp beat, registered and offered in the cycle after acceptance.
// Throughput is one beat per cycle: the sequencer state updates in the same
// edge that loads the result register, so req_ready only drops while a
// result sits in that register and rsp_ready is low.
// Reset (synchronous) empties the result register, puts the sequencer idle
// and restores the timing registers to their defaults.
module pulse_width_code_transmitter #(
   parameter int CODE_BITS = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [CODE_BITS-1:0]               req_code,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pin,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   // register write port
   input  logic                               csr_we,
   input  logic [pwct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwct_pkg::LEN_W-1:0]         csr_wdata
);
   import pwct_pkg::*;

   cfg_type    cfg_ff;
   result_type seq_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_pin_ff, rsp_busy_ff, rsp_done_ff;
   logic       accept;

   // Take a new beat whenever the result register is empty or draining.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // Timing registers: a new value is picked up when the next part loads
   // its length; the part under way keeps its count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_len    <= SHORT_LEN_RST;
         cfg_ff.long_len     <= LONG_LEN_RST;
         cfg_ff.gap_len      <= GAP_LEN_RST;
         cfg_ff.repeat_total <= REPEAT_TOTAL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_LEN:    cfg_ff.short_len    <= csr_wdata;
            CSR_LONG_LEN:     cfg_ff.long_len     <= csr_wdata;
            CSR_GAP_LEN:      cfg_ff.gap_len      <= csr_wdata;
            CSR_REPEAT_TOTAL: cfg_ff.repeat_total <= csr_wdata[REP_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the sequencer once per accepted beat.
   pwct_seq #(
      .CODE_BITS (CODE_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .func   (req_func),
      .code   (req_code),
      .cfg    (cfg_ff),
      .result (seq_result)
   );

   // Result register: hold while stalled, reload on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pin_ff  <= seq_result.pin;
         rsp_busy_ff <= seq_result.busy;
         rsp_done_ff <= seq_result.done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pin      = rsp_pin_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

[rtl/core/pwct_chk.sv]
// Port-level checker for the pulse width code transmitter, with its bind.
module pwct_chk (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pin,
   input logic rsp_busy_res,
   input logic rsp_done_res
);

   // an empty result register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with no result pending");

   // reset empties the result register
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present right after reset");

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pin)
         && $stable(rsp_busy_res) && $stable(rsp_done_res))
      else $error("stalled result beat changed");

   // end of the last frame only while busy, with the pin low
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res && !rsp_pin)
      else $error("done flagged outside a busy gap tick");

   // idle pin is low
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_pin)
      else $error("pin high while idle");

endmodule

bind pulse_width_code_transmitter pwct_chk u_pwct_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_pin      (rsp_pin),
   .rsp_busy_res (rsp_busy_res),
   .rsp_done_res (rsp_done_res)
);

[test/pwct_level_checker.sv]
// Checker for the code transmitter: predicts each result beat and compares it.
module pwct_level_checker #(
   parameter int CODE_BITS = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_func,
   input  logic [CODE_BITS-1:0]           req_code,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_pin,
   input  logic                           rsp_busy_res,
   input  logic                           rsp_done_res,
   input  logic                           csr_we,
   input  logic [pwct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwct_pkg::LEN_W-1:0]     csr_wdata,
   output int                             pending,
   output int                             failures
);
   import pwct_pkg::*;

   // timing registers as last written
   logic [LEN_W-1:0]     short_ticks;
   logic [LEN_W-1:0]     long_ticks;
   logic [LEN_W-1:0]     gap_ticks;
   logic [REP_W-1:0]     pass_target;

   // sequencer state
   logic [CODE_BITS-1:0] word;
   int unsigned          bit_idx;
   logic [REP_W-1:0]     passes_done;
   logic [PHASE_W-1:0]   seq_phase;
   logic [LEN_W-1:0]     ticks_left;

   result_type           level_q[$];
   int                   pending_count = 0;
   int                   fail_count = 0;
   string                field_name[3] = '{"done_res", "busy_res", "pin"};

   assign pending  = pending_count;
   assign failures = fail_count;

   function automatic logic [LEN_W-1:0] ticks_of(input logic [LEN_W-1:0] len);
      return (len == '0) ? LEN_W'(1) : len;
   endfunction

   // high part of the current bit: long for a one, short for a zero
   task automatic begin_mark();
      seq_phase  = PH_HIGH;
      ticks_left = word[CODE_BITS-1-bit_idx] ? ticks_of(long_ticks) : ticks_of(short_ticks);
   endtask

   task automatic step_transmitter(input logic func, input logic [CODE_BITS-1:0] code,
                                   output result_type lv);
      bit last_pass;
      lv = '0;
      if (func) begin
         if (seq_phase == PH_IDLE) begin
            word        = code;
            bit_idx     = 0;
            passes_done = '0;
            begin_mark();
         end
         lv.pin  = (seq_phase == PH_HIGH);
         lv.busy = 1'b1;
      end else if (seq_phase != PH_IDLE) begin
         lv.pin     = (seq_phase == PH_HIGH);
         lv.busy    = 1'b1;
         ticks_left = ticks_left - 1'b1;
         if (ticks_left == '0) begin
            case (seq_phase)
               PH_HIGH: begin
                  seq_phase  = PH_LOW;
                  ticks_left = word[CODE_BITS-1-bit_idx] ? ticks_of(short_ticks)
                                                         : ticks_of(long_ticks);
               end
               PH_LOW: begin
                  if (bit_idx >= CODE_BITS - 1) begin
                     seq_phase  = PH_GAP;
                     ticks_left = ticks_of(gap_ticks);
                  end else begin
                     bit_idx++;
                     begin_mark();
                  end
               end
               default: begin
                  last_pass = (int'(passes_done) + 1 >=
                               ((pass_target == '0) ? 1 : int'(pass_target)));
                  passes_done = passes_done + 1'b1;
                  bit_idx     = 0;
                  if (last_pass) begin
                     seq_phase = PH_IDLE;
                     lv.done   = 1'b1;
                  end else begin
                     begin_mark();
                  end
               end
            endcase
         end
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         short_ticks = SHORT_LEN_RST;
         long_ticks  = LONG_LEN_RST;
         gap_ticks   = GAP_LEN_RST;
         pass_target = REPEAT_TOTAL_RST;
         word        = '0;
         bit_idx     = 0;
         passes_done = '0;
         seq_phase   = PH_IDLE;
         ticks_left  = '0;
         level_q.delete();
      end else begin
         // a result leaving now belongs to an earlier request, so retire it first
         if (rsp_valid && rsp_ready) begin
            got = '{pin: rsp_pin, busy: rsp_busy_res, done: rsp_done_res};
            if (level_q.size() == 0) begin
               $error("result beat with no expected result waiting");
               fail_count++;
            end else begin
               want = level_q.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (got[i] !== want[i]) begin
                     $error("%s mismatch: expected %0b, got %0b", field_name[i], want[i], got[i]);
                     fail_count++;
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SHORT_LEN:    short_ticks = csr_wdata;
               CSR_LONG_LEN:     long_ticks  = csr_wdata;
               CSR_GAP_LEN:      gap_ticks   = csr_wdata;
               CSR_REPEAT_TOTAL: pass_target = csr_wdata[REP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_transmitter(req_func, req_code, want);
            level_q.push_back(want);
         end
      end
      pending_count = level_q.size();
   end

endmodule

[test/tb_pulse_width_code_transmitter.sv]
// Testbench top for the code transmitter: stimulus, handshake idling and the verdict.
module tb_pulse_width_code_transmitter;
   import pwct_pkg::*;

   localparam int CODE_BITS     = 25;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BEATS   = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = 1'b0;
   logic [CODE_BITS-1:0] req_code = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_pin;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SHORT_LEN;
   logic [LEN_W-1:0]     csr_wdata = '0;

   int pending;
   int failures;

   // Idling controls: sender_calm drops the gaps between request beats,
   // rx_steady keeps the receiver ready in every cycle.
   bit sender_calm = 1'b0;
   bit rx_steady   = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pulse_width_code_transmitter #(
      .CODE_BITS(CODE_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_code     (req_code),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pin      (rsp_pin),
      .rsp_busy_res (rsp_busy_res),
      .rsp_done_res (rsp_done_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pwct_level_checker #(
      .CODE_BITS(CODE_BITS)
   ) levels (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_code     (req_code),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pin      (rsp_pin),
      .rsp_busy_res (rsp_busy_res),
      .rsp_done_res (rsp_done_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pending      (pending),
      .failures     (failures)
   );

   // Gap length in cycles: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   // Code word: all clear or all set now and then, otherwise random bits.
   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CODE_BITS'($urandom());
      endcase
   endfunction

   // Offer one request beat, hold it until accepted, then maybe leave a gap.
   // Valid stays high when no gap follows, so back-to-back beats never
   // lower and raise it in the same step.
   task automatic offer(input logic func, input logic [CODE_BITS-1:0] code);
      int gap;
      req_valid <= 1'b1;
      req_func  <= func;
      req_code  <= code;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (!sender_calm && gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result has come back.
   // Sample the count at the falling edge, clear of the checker's update.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Write all four timing registers on successive edges, keeping the
   // write enable high across them.
   task automatic load_timing(input logic [LEN_W-1:0] short_val, long_val, gap_val, rep_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_SHORT_LEN;
      csr_wdata <= short_val;
      @(posedge clock);
      csr_index <= CSR_LONG_LEN;
      csr_wdata <= long_val;
      @(posedge clock);
      csr_index <= CSR_GAP_LEN;
      csr_wdata <= gap_val;
      @(posedge clock);
      csr_index <= CSR_REPEAT_TOTAL;
      csr_wdata <= rep_val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int rep;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Zero in every register: each part lasts one tick and
      // a single pass goes out, so one bit takes two ticks.
      load_timing('0, '0, '0, '0);
      offer(1'b0, '1);                 // tick while idle
      offer(1'b1, '1);                 // start with every code bit set
      offer(1'b1, '0);                 // start while busy: ignored
      repeat (2 * CODE_BITS + 1) offer(1'b0, pick_code());   // last tick flags done
      offer(1'b0, '0);                 // idle again, pin low
      offer(1'b1, '0);                 // start with every code bit clear
      repeat (6) offer(1'b0, pick_code());
      drain_results();

      // Random part: small lengths so that many frames and runs complete.
      // Each phase rewrites the registers once the result side is empty;
      // the repeat write carries random upper bits that must be dropped.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if ($urandom_range(0, 4) == 0)
            rep = ($urandom_range(0, 1) == 0) ? 0 : 15;
         else
            rep = $urandom_range(1, 2);
         load_timing(LEN_W'($urandom_range(0, 2)), LEN_W'($urandom_range(1, 3)),
                     LEN_W'($urandom_range(0, 5)),
                     {(LEN_W-REP_W)'($urandom()), REP_W'(rep)});
         sender_calm = ($urandom_range(0, 3) == 0);
         offer(1'b1, pick_code());
         repeat (PHASE_BEATS - 1) offer($urandom_range(0, 99) < 3, pick_code());
         // pause the sender until every result is back
         drain_results();
         sender_calm = 1'b0;
      end

      // Top values: every register all ones. Start a run and tick into the
      // first 16-bit count without idling.
      sender_calm = 1'b1;
      rx_steady   = 1'b1;
      load_timing('1, '1, '1, '1);
      offer(1'b1, pick_code());
      repeat (30) offer(1'b0, pick_code());
      drain_results();

      // let the last result settle, then give the verdict
      repeat (4) @(negedge clock);
      if (failures == 0)
         $display("pulse_width_code_transmitter verification clean");
      else
         $display("pulse_width_code_transmitter verification failed");
      $finish;
   end

   // Receiver: ready for a run of cycles, then stall for a gap. Once, well
   // into the random part, hold off for a long stretch while the sender keeps
   // offering, so the result register fills and the request side backs up.
   initial begin : receiver
      int  run_len;
      int  stall_len;
      int  cycles_seen;
      bit  long_hold_done;
      cycles_seen    = 0;
      long_hold_done = 1'b0;
      @(posedge clock);
      forever begin
         run_len = rx_steady ? 1 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         cycles_seen += run_len;
         if (!rx_steady) begin
            if (!long_hold_done && cycles_seen >= 1000) begin
               long_hold_done = 1'b1;
               stall_len      = 120;
            end else begin
               stall_len = pick_gap();
            end
            if (stall_len > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall_len) @(posedge clock);
               cycles_seen += stall_len;
            end
         end
      end
   end

   // Watchdog: a correct run ends far sooner, even with every gap at its longest.
   initial begin : watchdog
      #5000000;
      $display("pulse_width_code_transmitter verification failed");
      $finish;
   end

endmodule
